// ===== hdl/blist_pkg.sv =====
// Shared constants, command and status codes and the store request type
// for the bounded list engine. No dependencies.
package blist_pkg;

  // Sizing.
  localparam int LIST_DEPTH = 64;
  localparam int DATA_W     = 32;
  localparam int ACT_W      = 4;
  localparam int STAT_W     = 3;
  localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  // Command codes.
  localparam logic [ACT_W-1:0] ACT_ADD_FRONT  = 4'd0;
  localparam logic [ACT_W-1:0] ACT_ADD_BACK   = 4'd1;
  localparam logic [ACT_W-1:0] ACT_REM_FRONT  = 4'd2;
  localparam logic [ACT_W-1:0] ACT_REM_BACK   = 4'd3;
  localparam logic [ACT_W-1:0] ACT_CLEAR      = 4'd4;
  localparam logic [ACT_W-1:0] ACT_REM_VALUE  = 4'd5;
  localparam logic [ACT_W-1:0] ACT_READ_ALL   = 4'd6;
  localparam logic [ACT_W-1:0] ACT_READ_FIRST = 4'd7;
  localparam logic [ACT_W-1:0] ACT_READ_LAST  = 4'd8;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_DONE     = 3'd0;
  localparam logic [STAT_W-1:0] ST_ELEM     = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

  // Access request from the sequencer to the entry store.
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } ram_req_t;

endpackage

// ===== hdl/blist_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module blist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write and registered read; the read data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/blist_ctrl.sv =====
// Command sequencer for the bounded list engine: head and count registers,
// store walks for remove-by-value and reads, and the result register.
// Depends on blist_pkg.
module blist_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [blist_pkg::ACT_W-1:0]     in_action,
  input  logic signed [blist_pkg::DATA_W-1:0] in_operand,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [blist_pkg::STAT_W-1:0]    out_status,
  output logic signed [blist_pkg::DATA_W-1:0] out_element,
  output logic                            out_last_of_run,
  output blist_pkg::ram_req_t             ram_req,
  input  logic [blist_pkg::DATA_W-1:0]    ram_rd_data
);
  import blist_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_READ = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ACT_W-1:0]  act_r, act_nxt;
  logic [DATA_W-1:0] opnd_r, opnd_nxt;
  logic [CNT_W-1:0]  rd_k_r, rd_k_nxt;
  logic [CNT_W-1:0]  end_k_r, end_k_nxt;
  logic              dv_r, dv_nxt;
  logic [CNT_W-1:0]  k_d_r, k_d_nxt;
  logic [ADDR_W-1:0] addr_d_r, addr_d_nxt;
  logic [ADDR_W-1:0] prev_addr_r, prev_addr_nxt;
  logic              found_r, found_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [DATA_W-1:0] out_element_r, out_element_nxt;
  logic              out_last_r, out_last_nxt;

  logic              out_can_load;
  logic [DATA_W-2:0] n_val;
  logic              n_zero;
  logic              n_big;
  logic [CNT_W-1:0]  len;
  logic              list_full;
  logic              list_empty;
  logic [ADDR_W-1:0] head_dec;
  logic [ADDR_W-1:0] rd_slot;
  logic              match;
  logic              last_arr;
  logic              res_load;
  logic [STAT_W-1:0] res_status;

  // Position of an offset from a base, wrapped modulo the list depth.
  function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(LIST_DEPTH)) begin
      sum = sum - (CNT_W+1)'(LIST_DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

  // Decoded operand and list status.
  assign out_can_load = !out_valid_r || out_ready;
  assign n_val      = opnd_r[DATA_W-1] ? '0 : opnd_r[DATA_W-2:0];
  assign n_zero     = (n_val == '0);
  assign n_big      = (n_val > (DATA_W-1)'(count_r));
  assign len        = n_big ? count_r : n_val[CNT_W-1:0];
  assign list_full  = (count_r == CNT_W'(LIST_DEPTH));
  assign list_empty = (count_r == '0);
  assign head_dec   = (head_r == '0) ? ADDR_W'(LIST_DEPTH - 1) : head_r - 1'b1;
  assign rd_slot    = slot_of(head_r, rd_k_r);
  assign match      = (ram_rd_data == opnd_r);
  assign last_arr   = (k_d_r == end_k_r - 1'b1);

  // Next-state logic.
  always_comb begin
    state_nxt       = state_r;
    head_nxt        = head_r;
    count_nxt       = count_r;
    act_nxt         = act_r;
    opnd_nxt        = opnd_r;
    rd_k_nxt        = rd_k_r;
    end_k_nxt       = end_k_r;
    dv_nxt          = 1'b0;
    k_d_nxt         = k_d_r;
    addr_d_nxt      = addr_d_r;
    prev_addr_nxt   = prev_addr_r;
    found_nxt       = found_r;
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_element_nxt = out_element_r;
    out_last_nxt    = out_last_r;
    res_load        = 1'b0;
    res_status      = ST_DONE;
    ram_req.wr_en   = 1'b0;
    ram_req.wr_addr = head_dec;
    ram_req.wr_data = opnd_r;
    ram_req.rd_en   = 1'b0;
    ram_req.rd_addr = rd_slot;

    // The result register empties when its transaction completes.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt   = in_action;
          opnd_nxt  = in_operand;
          state_nxt = S_EXEC;
        end
      end

      // Execute the command once the result register is free.
      S_EXEC: begin
        if (out_can_load) begin
          state_nxt = S_IDLE;
          res_load  = 1'b1;
          case (act_r)
            ACT_ADD_FRONT: begin
              if (list_full) begin
                res_status = ST_FULL;
              end else begin
                head_nxt        = head_dec;
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = head_dec;
                count_nxt       = count_r + 1'b1;
              end
            end
            ACT_ADD_BACK: begin
              if (list_full) begin
                res_status = ST_FULL;
              end else begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = slot_of(head_r, count_r);
                count_nxt       = count_r + 1'b1;
              end
            end
            ACT_REM_FRONT: begin
              if (list_empty) begin
                res_status = ST_EMPTY;
              end else begin
                head_nxt  = slot_of(head_r, CNT_W'(1));
                count_nxt = count_r - 1'b1;
              end
            end
            ACT_REM_BACK: begin
              if (list_empty) begin
                res_status = ST_EMPTY;
              end else begin
                count_nxt = count_r - 1'b1;
              end
            end
            ACT_CLEAR: begin
              head_nxt  = '0;
              count_nxt = '0;
            end
            ACT_REM_VALUE: begin
              if (list_empty) begin
                res_status = ST_EMPTY;
              end else begin
                res_load  = 1'b0;
                rd_k_nxt  = '0;
                end_k_nxt = count_r;
                found_nxt = 1'b0;
                state_nxt = S_SCAN;
              end
            end
            ACT_READ_ALL: begin
              if (list_empty) begin
                res_status = ST_EMPTY;
              end else begin
                res_load  = 1'b0;
                rd_k_nxt  = '0;
                end_k_nxt = count_r;
                state_nxt = S_READ;
              end
            end
            ACT_READ_FIRST: begin
              if (list_empty) begin
                res_status = ST_EMPTY;
              end else if (!n_zero) begin
                res_load  = 1'b0;
                rd_k_nxt  = '0;
                end_k_nxt = len;
                state_nxt = S_READ;
              end
            end
            ACT_READ_LAST: begin
              if (list_empty) begin
                res_status = ST_EMPTY;
              end else if (!n_zero) begin
                res_load  = 1'b0;
                rd_k_nxt  = count_r - len;
                end_k_nxt = count_r;
                state_nxt = S_READ;
              end
            end
            default: begin
              res_status = ST_DONE;
            end
          endcase
        end
      end

      // Remove by value: one read per cycle; after the match each entry
      // arriving from the store is written one position toward the front.
      S_SCAN: begin
        if (rd_k_r < end_k_r) begin
          ram_req.rd_en = 1'b1;
          rd_k_nxt      = rd_k_r + 1'b1;
          dv_nxt        = 1'b1;
          k_d_nxt       = rd_k_r;
          addr_d_nxt    = rd_slot;
        end
        if (dv_r) begin
          prev_addr_nxt = addr_d_r;
          if (found_r) begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = prev_addr_r;
            ram_req.wr_data = ram_rd_data;
          end else if (match) begin
            found_nxt = 1'b1;
          end
          if (last_arr) begin
            state_nxt = S_IDLE;
            res_load  = 1'b1;
            if (found_r || match) begin
              count_nxt  = count_r - 1'b1;
              res_status = ST_DONE;
            end else begin
              res_status = ST_NOTFOUND;
            end
          end
        end
      end

      // Reads: one store read in flight; it is issued only when the result
      // register is sure to be free on arrival.
      S_READ: begin
        if (dv_r) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = ST_ELEM;
          out_element_nxt = ram_rd_data;
          out_last_nxt    = last_arr;
          if (last_arr) begin
            state_nxt = S_IDLE;
          end
        end else if (out_can_load && (rd_k_r < end_k_r)) begin
          ram_req.rd_en = 1'b1;
          rd_k_nxt      = rd_k_r + 1'b1;
          dv_nxt        = 1'b1;
          k_d_nxt       = rd_k_r;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Single status result.
    if (res_load) begin
      out_valid_nxt   = 1'b1;
      out_status_nxt  = res_status;
      out_element_nxt = '0;
      out_last_nxt    = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      dv_r        <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      dv_r        <= dv_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    act_r         <= act_nxt;
    opnd_r        <= opnd_nxt;
    rd_k_r        <= rd_k_nxt;
    end_k_r       <= end_k_nxt;
    k_d_r         <= k_d_nxt;
    addr_d_r      <= addr_d_nxt;
    prev_addr_r   <= prev_addr_nxt;
    out_status_r  <= out_status_nxt;
    out_element_r <= out_element_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_element     = out_element_r;
  assign out_last_of_run = out_last_r;

endmodule

// ===== hdl/bounded_list_engine.sv =====
// Top level of the bounded list engine: command sequencer and entry store.
// Depends on blist_pkg, blist_ram and blist_ctrl.
//
// A double-ended list of up to LIST_DEPTH signed 32-bit values held in one
// synchronous RAM with head and count registers. Every command transaction
// gives one status result, except reads that find elements, which give
// one result per element from front to back with last_of_run on the final
// one. Edit commands are executed once the result register is free.
// Remove-by-value walks the list through the single RAM read port, one
// entry per cycle, shifting later entries forward as it goes. Reads keep
// one RAM read in flight, each sent only when the output register will be
// free to take it. A new command is accepted while the last result waits.
module bounded_list_engine (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [blist_pkg::ACT_W-1:0]          in_action,
  input  logic signed [blist_pkg::DATA_W-1:0]  in_operand,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [blist_pkg::STAT_W-1:0]         out_status,
  output logic signed [blist_pkg::DATA_W-1:0]  out_element,
  output logic                                 out_last_of_run
);
  import blist_pkg::*;

  ram_req_t          ram_req;
  logic [DATA_W-1:0] ram_rd_data;

  // Sequencer.
  blist_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_operand      (in_operand),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_element     (out_element),
    .out_last_of_run (out_last_of_run),
    .ram_req         (ram_req),
    .ram_rd_data     (ram_rd_data)
  );

  // Entry store.
  blist_ram #(
    .WIDTH (DATA_W),
    .DEPTH (LIST_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_req.wr_en),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.wr_data),
    .rd_en   (ram_req.rd_en),
    .rd_addr (ram_req.rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule
